[rtl/lbm_pkg.sv]
`default_nettype none
package lbm_pkg;

  localparam int LABEL_W     = 16;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_LINE_DEFAULT   = 1024;
  localparam int MAX_LINES_DEFAULT  = 1024;
  localparam int LABEL_BITS_DEFAULT = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam int RESET_LINE_LENGTH = 64;
  localparam int RESET_LINE_COUNT  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINE_LENGTH  = 2'd0,
    CFG_LINE_COUNT   = 2'd1,
    CFG_CONNECTIVITY = 2'd2
  } cfg_index_t;

  localparam logic CMD_FLUSH  = 1'b1;
  localparam logic CONN_EIGHT = 1'b0;
  localparam logic CONN_FOUR  = 1'b1;

  // per-item control carried from the front part to the window
  typedef struct packed {
    logic emit;
    logic last;
    logic west_edge;
    logic east_edge;
    logic north_edge;
    logic south_edge;
  } item_ctl_t;

  localparam int ITEM_CTL_W = $bits(item_ctl_t);

endpackage
`default_nettype wire

[rtl/lbm_front.sv]
`default_nettype none
module lbm_front #(
  parameter int MAX_LINE   = lbm_pkg::MAX_LINE_DEFAULT,
  parameter int MAX_LINES  = lbm_pkg::MAX_LINES_DEFAULT,
  parameter int LABEL_BITS = lbm_pkg::LABEL_BITS_DEFAULT,
  parameter int XW         = $clog2(MAX_LINE),
  parameter int CW         = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [XW-1:0]                len_last,
  input  logic [CW-1:0]                cnt_last,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [lbm_pkg::LABEL_W-1:0]  label,
  input  logic                         queue_full,
  output logic                         push,
  output logic [LABEL_BITS-1:0]        push_lab,
  output logic [XW-1:0]                push_x,
  output lbm_pkg::item_ctl_t           push_ctl
);
  import lbm_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic [XW-1:0]    in_x;
  logic [CW-1:0]    in_y;
  logic             done;
  logic [LEN_W-1:0] lead;
  logic             primed;
  logic [XW-1:0]    ox;
  logic [CW-1:0]    oy;

  logic accept;
  logic take;
  logic x_wrap;
  logic y_wrap;
  logic frame_end;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  // a flush before all pixels are in is dropped
  assign take      = accept && (done || command != CMD_FLUSH);
  assign x_wrap    = in_x == len_last;
  assign y_wrap    = in_y == cnt_last;
  assign frame_end = primed && ox == len_last && oy == cnt_last;

  assign push     = take;
  assign push_lab = done ? '0 : LABEL_BITS'(label);
  assign push_x   = in_x;

  always_comb begin
    push_ctl            = '0;
    push_ctl.emit       = primed;
    push_ctl.last       = frame_end;
    push_ctl.west_edge  = ox == '0;
    push_ctl.east_edge  = ox == len_last;
    push_ctl.north_edge = oy == '0;
    push_ctl.south_edge = oy == cnt_last;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_x   <= '0;
      in_y   <= '0;
      done   <= 1'b0;
      lead   <= '0;
      primed <= 1'b0;
      ox     <= '0;
      oy     <= '0;
    end else if (take) begin
      if (frame_end) begin
        in_x   <= '0;
        in_y   <= '0;
        done   <= 1'b0;
        lead   <= '0;
        primed <= 1'b0;
        ox     <= '0;
        oy     <= '0;
      end else begin
        in_x <= x_wrap ? '0 : in_x + 1'b1;
        if (!done && x_wrap) begin
          if (y_wrap) begin
            done <= 1'b1;
            in_y <= '0;
          end else begin
            in_y <= in_y + 1'b1;
          end
        end
        // results start once one line plus one pixel has gone in
        if (!primed) begin
          lead <= lead + 1'b1;
          if (lead == LEN_W'(len_last) + LEN_W'(1)) begin
            primed <= 1'b1;
          end
        end else begin
          if (ox == len_last) begin
            ox <= '0;
            oy <= oy + 1'b1;
          end else begin
            ox <= ox + 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lbm_fifo.sv]
`default_nettype none
module lbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lbm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);
  import lbm_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full  = fill == NW'(DEPTH);
  assign valid = fill != '0;
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lbm_back.sv]
`default_nettype none
module lbm_back #(
  parameter int MAX_LINE   = lbm_pkg::MAX_LINE_DEFAULT,
  parameter int LABEL_BITS = lbm_pkg::LABEL_BITS_DEFAULT,
  parameter int XW         = $clog2(MAX_LINE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  conn,
  input  logic                  q_valid,
  input  logic [LABEL_BITS-1:0] q_lab,
  input  logic [XW-1:0]         q_x,
  input  lbm_pkg::item_ctl_t    q_ctl,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  boundary,
  output logic                  last
);
  import lbm_pkg::*;

  // one entry per column: {upper line, middle line}
  logic [2*LABEL_BITS-1:0] store [MAX_LINE];
  logic [2*LABEL_BITS-1:0] rd_data;
  logic [2*LABEL_BITS-1:0] fwd_data;
  logic                    fwd;
  logic [2*LABEL_BITS-1:0] col;
  logic [2*LABEL_BITS-1:0] wr_data;

  logic                  adv;
  logic                  s1_valid;
  logic [LABEL_BITS-1:0] s1_lab;
  logic [XW-1:0]         s1_x;
  item_ctl_t             s1_ctl;
  logic                  s2_valid;
  item_ctl_t             s2_ctl;

  logic [LABEL_BITS-1:0] win [3][3];
  logic [LABEL_BITS-1:0] center;
  logic d_nw, d_n, d_ne, d_w, d_e, d_sw, d_s, d_se;
  logic four_hit, eight_hit, edge_hit;

  // whole back part moves together whenever the output slot can take a result
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // same column written in the cycle it is read again (line length of one)
  assign col     = fwd ? fwd_data : rd_data;
  assign wr_data = {col[LABEL_BITS-1:0], s1_lab};

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= store[q_x];
      if (s1_valid) begin
        store[s1_x] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lab   <= q_lab;
      s1_x     <= q_x;
      s1_ctl   <= q_ctl;
      fwd      <= s1_valid && q_x == s1_x;
      fwd_data <= wr_data;
      s2_ctl   <= s1_ctl;
      boundary <= edge_hit;
      last     <= s2_ctl.last;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= col[2*LABEL_BITS-1:LABEL_BITS];
        win[1][2] <= col[LABEL_BITS-1:0];
        win[2][2] <= s1_lab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_ctl.emit;
    end
  end

  // rows: upper, middle, current line; columns: west, centre, east
  assign center = win[1][1];
  assign d_nw = s2_ctl.north_edge || s2_ctl.west_edge || win[0][0] != center;
  assign d_n  = s2_ctl.north_edge || win[0][1] != center;
  assign d_ne = s2_ctl.north_edge || s2_ctl.east_edge || win[0][2] != center;
  assign d_w  = s2_ctl.west_edge || win[1][0] != center;
  assign d_e  = s2_ctl.east_edge || win[1][2] != center;
  assign d_sw = s2_ctl.south_edge || s2_ctl.west_edge || win[2][0] != center;
  assign d_s  = s2_ctl.south_edge || win[2][1] != center;
  assign d_se = s2_ctl.south_edge || s2_ctl.east_edge || win[2][2] != center;

  assign four_hit  = d_n || d_w || d_e || d_s;
  assign eight_hit = four_hit || d_nw || d_ne || d_sw || d_se;
  assign edge_hit  = center != '0 && ((conn == CONN_FOUR) ? four_hit : eight_hit);

endmodule
`default_nettype wire

[rtl/label_boundary_mask_core.sv]
`default_nettype none
// Throughput: one item per cycle, sustained, while the result side keeps taking.
// Path: once the item one line plus one pixel later has been taken, the result for a pixel
// passes the queue, line store read, window and output register, and then leaves.
// Reset: counters, queue and valid flags clear; sizes return to 64 x 64, eight-connected.
// Line stores are not cleared; entries only reach results once written in the frame.
module label_boundary_mask_core #(
  parameter int MAX_LINE   = lbm_pkg::MAX_LINE_DEFAULT,
  parameter int MAX_LINES  = lbm_pkg::MAX_LINES_DEFAULT,
  parameter int LABEL_BITS = lbm_pkg::LABEL_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [lbm_pkg::LABEL_W-1:0]      label,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             boundary,
  output logic                             last
);
  import lbm_pkg::*;

  localparam int XW     = $clog2(MAX_LINE);
  localparam int CW     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int RST_LEN = (RESET_LINE_LENGTH > MAX_LINE) ? MAX_LINE : RESET_LINE_LENGTH;
  localparam int RST_CNT = (RESET_LINE_COUNT > MAX_LINES) ? MAX_LINES : RESET_LINE_COUNT;
  localparam int DATA_W = LABEL_BITS + XW + ITEM_CTL_W;

  // sizes are held as last index, already saturated
  logic [XW-1:0] len_last, len_last_next;
  logic [CW-1:0] cnt_last, cnt_last_next;
  logic          conn, conn_next;
  logic          clear;

  logic                  push;
  logic [LABEL_BITS-1:0] push_lab;
  logic [XW-1:0]         push_x;
  item_ctl_t             push_ctl;
  logic                  queue_full;
  logic                  q_pop;
  logic                  q_valid;
  logic [DATA_W-1:0]     q_data;
  logic [LABEL_BITS-1:0] q_lab;
  logic [XW-1:0]         q_x;
  item_ctl_t             q_ctl;

  assign cfg_ready = 1'b1;

  always_comb begin
    len_last_next = len_last;
    cnt_last_next = cnt_last;
    conn_next     = conn;
    clear         = 1'b0;
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_LINE_LENGTH: begin
          clear = 1'b1;
          if (cfg_data == '0) begin
            len_last_next = '0;
          end else if (32'(cfg_data) > 32'(MAX_LINE)) begin
            len_last_next = XW'(MAX_LINE - 1);
          end else begin
            len_last_next = XW'(cfg_data - CFG_DATA_W'(1));
          end
        end
        CFG_LINE_COUNT: begin
          clear = 1'b1;
          if (cfg_data == '0) begin
            cnt_last_next = '0;
          end else if (32'(cfg_data) > 32'(MAX_LINES)) begin
            cnt_last_next = CW'(MAX_LINES - 1);
          end else begin
            cnt_last_next = CW'(cfg_data - CFG_DATA_W'(1));
          end
        end
        CFG_CONNECTIVITY: begin
          clear     = 1'b1;
          conn_next = cfg_data[0];
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_last <= XW'(RST_LEN - 1);
      cnt_last <= CW'(RST_CNT - 1);
      conn     <= CONN_EIGHT;
    end else begin
      len_last <= len_last_next;
      cnt_last <= cnt_last_next;
      conn     <= conn_next;
    end
  end

  lbm_front #(
    .MAX_LINE   (MAX_LINE),
    .MAX_LINES  (MAX_LINES),
    .LABEL_BITS (LABEL_BITS),
    .XW         (XW),
    .CW         (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .len_last   (len_last),
    .cnt_last   (cnt_last),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .label      (label),
    .queue_full (queue_full),
    .push       (push),
    .push_lab   (push_lab),
    .push_x     (push_x),
    .push_ctl   (push_ctl)
  );

  lbm_fifo #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_lab, push_x, push_ctl}),
    .full      (queue_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign q_lab = q_data[DATA_W-1 -: LABEL_BITS];
  assign q_x   = q_data[ITEM_CTL_W +: XW];
  assign q_ctl = item_ctl_t'(q_data[ITEM_CTL_W-1:0]);

  lbm_back #(
    .MAX_LINE   (MAX_LINE),
    .LABEL_BITS (LABEL_BITS),
    .XW         (XW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .conn      (conn),
    .q_valid   (q_valid),
    .q_lab     (q_lab),
    .q_x       (q_x),
    .q_ctl     (q_ctl),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .boundary  (boundary),
    .last      (last)
  );

endmodule
`default_nettype wire
